[rtl/core/nnue_pkg.sv]
// ----------------------------------------------------------------------------
// nnue_pkg
// Shared sizes, command codes and word types for the NNUE evaluator.
// ----------------------------------------------------------------------------
package nnue_pkg;

    localparam int HIDDEN = 256;
    localparam int INPUTS = 1024;
    localparam int LANES  = 16;     // power of two

    localparam int NGRP   = (HIDDEN + LANES - 1) / LANES;
    localparam int LW     = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int GW     = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int FAW    = (INPUTS > 1) ? $clog2(INPUTS) : 1;
    localparam int WDEPTH = NGRP * INPUTS;
    localparam int AW     = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int NQ     = (LANES + 3) / 4;

    // command codes passed from front to back
    localparam logic [2:0] OP_WL1 = 3'd0;
    localparam logic [2:0] OP_WB  = 3'd1;
    localparam logic [2:0] OP_WO  = 3'd2;
    localparam logic [2:0] OP_CLR = 3'd3;
    localparam logic [2:0] OP_ADD = 3'd4;
    localparam logic [2:0] OP_SUB = 3'd5;
    localparam logic [2:0] OP_SCR = 3'd6;
    localparam logic [2:0] OP_INV = 3'd7;   // out-of-range write: only drops valid

    // input modes
    localparam logic [2:0] MD_WL1 = 3'd0;
    localparam logic [2:0] MD_WB  = 3'd1;
    localparam logic [2:0] MD_WO  = 3'd2;
    localparam logic [2:0] MD_CLR = 3'd3;
    localparam logic [2:0] MD_ADD = 3'd4;
    localparam logic [2:0] MD_SUB = 3'd5;
    localparam logic [2:0] MD_SCR = 3'd6;

    typedef struct packed {
        logic [2:0]         mode;
        logic [15:0]        feature_index;
        logic [7:0]         hidden_index;
        logic signed [15:0] value;
    } t_in;

    typedef struct packed {
        logic signed [63:0] score;
        logic               was_valid;
    } t_out;

    typedef struct packed {
        logic [2:0]         op;
        logic [LW-1:0]      lane;
        logic [GW-1:0]      grp;
        logic [FAW-1:0]     feat;
        logic signed [15:0] value;
    } t_cmd;

endpackage

[rtl/core/nnue_front.sv]
// ----------------------------------------------------------------------------
// nnue_front
// Input stage: takes words, decodes mode and range checks into commands.
// ----------------------------------------------------------------------------
module nnue_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  nnue_pkg::t_in i_in,
    output logic          o_cmd_v,
    output nnue_pkg::t_cmd o_cmd,
    input  logic          i_cmd_full
);
    import nnue_pkg::*;

    logic r_v, n_v;
    t_cmd r_cmd, n_cmd;
    logic keep;
    logic h_ok, f_ok;

    assign full    = r_v & i_cmd_full;
    assign o_cmd_v = r_v;
    assign o_cmd   = r_cmd;

    assign h_ok = int'(i_in.hidden_index) < HIDDEN;
    assign f_ok = int'(i_in.feature_index) < INPUTS;

    always_comb begin
        n_cmd.lane  = LW'(i_in.hidden_index % LANES);
        n_cmd.grp   = GW'(i_in.hidden_index / LANES);
        n_cmd.feat  = FAW'(i_in.feature_index);
        n_cmd.value = i_in.value;
        n_cmd.op    = OP_INV;
        keep        = 1'b1;
        case (i_in.mode)
            MD_WL1: n_cmd.op = (h_ok && f_ok) ? OP_WL1 : OP_INV;
            MD_WB:  n_cmd.op = h_ok ? OP_WB : OP_INV;
            MD_WO:  n_cmd.op = h_ok ? OP_WO : OP_INV;
            MD_CLR: n_cmd.op = OP_CLR;
            MD_ADD: begin
                n_cmd.op = OP_ADD;
                keep     = f_ok;
            end
            MD_SUB: begin
                n_cmd.op = OP_SUB;
                keep     = f_ok;
            end
            MD_SCR: n_cmd.op = OP_SCR;
            default: keep = 1'b0;
        endcase
    end

    always_comb begin
        n_v = r_v & i_cmd_full;
        if (push && !full) begin
            n_v = keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push && !full) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

[rtl/core/nnue_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// nnue_cmd_fifo
// Four-entry command queue between front and back.
// ----------------------------------------------------------------------------
module nnue_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  nnue_pkg::t_cmd i_wdata,
    output logic           o_full,
    input  logic           i_rd,
    output logic           o_empty,
    output nnue_pkg::t_cmd o_rdata
);
    import nnue_pkg::*;

    t_cmd       r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       wr, rd;

    assign o_full  = r_cnt == 3'd4;
    assign o_empty = r_cnt == 3'd0;
    assign o_rdata = r_mem[r_rp];
    assign wr      = i_wr & !o_full;
    assign rd      = i_rd & !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + 2'd1;
            end
            if (rd) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= r_cnt + {2'b0, wr} - {2'b0, rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

[rtl/core/nnue_back.sv]
// ----------------------------------------------------------------------------
// nnue_back
// Execution engine: lane memories, accumulator updates and scoring pipeline.
// ----------------------------------------------------------------------------
module nnue_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_empty,
    input  nnue_pkg::t_cmd      i_cmd,
    output logic                o_cmd_pop,
    input  logic                i_cfg_we,
    input  logic signed [31:0]  i_cfg_data,
    output logic                empty,
    input  logic                pop,
    output nnue_pkg::t_out      o_out
);
    import nnue_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]         r_st;
    logic [2:0]         r_op;
    logic [FAW-1:0]     r_feat;
    logic [GW-1:0]      r_g;
    logic [1:0]         r_dr;
    logic               r_acc_valid;
    logic [NGRP-1:0]    r_row_ok;
    logic signed [31:0] r_obias;
    logic               r_out_v;
    t_out               r_out;

    logic               r_s1_v, r_s2_v, r_s3_v;
    logic [GW-1:0]      r_s1_g;
    logic               r_s1_ok;
    logic signed [31:0] r_acc_rd [LANES];
    logic signed [15:0] r_w_rd   [LANES];
    logic signed [15:0] r_b_rd   [LANES];
    logic signed [15:0] r_ow_rd  [LANES];
    logic signed [47:0] r_prod   [LANES];
    logic signed [49:0] r_part   [NQ];
    logic signed [63:0] r_sum;

    logic               start, run, last_g;
    logic [AW-1:0]      rd_addr, wr_addr;
    logic signed [63:0] part_sum;

    assign empty = !r_out_v;
    assign o_out = r_out;

    assign run    = r_st == ST_RUN;
    assign last_g = int'(r_g) == NGRP - 1;
    assign start  = (r_st == ST_IDLE) && !i_cmd_empty && (i_cmd.op != OP_SCR || !r_out_v);
    assign o_cmd_pop = start;

    assign rd_addr = AW'(int'(r_g) * INPUTS) + AW'(r_feat);
    assign wr_addr = AW'(int'(i_cmd.grp) * INPUTS) + AW'(i_cmd.feat);

    // lane memories
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic signed [15:0] wmem [WDEPTH];
        logic signed [15:0] bmem [NGRP];
        logic signed [15:0] omem [NGRP];
        logic signed [31:0] amem [NGRP];
        logic signed [31:0] acc_in;
        logic signed [32:0] upd;
        logic signed [31:0] sat;
        logic signed [31:0] relu;
        logic               live;

        assign live   = int'(r_s1_g) * LANES + l < HIDDEN;
        assign acc_in = r_s1_ok ? r_acc_rd[l] : 32'sd0;
        assign upd    = (r_op == OP_SUB) ? (33'(acc_in) - 33'(r_w_rd[l]))
                                         : (33'(acc_in) + 33'(r_w_rd[l]));
        assign sat    = (upd > 33'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                        (upd < -33'sh0_8000_0000) ? 32'sh8000_0000 : upd[31:0];
        assign relu   = (acc_in[31] || !live) ? 32'sd0 : acc_in;

        always_ff @(posedge i_clk) begin
            if (start && i_cmd.op == OP_WL1 && int'(i_cmd.lane) == l) begin
                wmem[wr_addr] <= i_cmd.value;
            end
            if (start && i_cmd.op == OP_WB && int'(i_cmd.lane) == l) begin
                bmem[i_cmd.grp] <= i_cmd.value;
            end
            if (start && i_cmd.op == OP_WO && int'(i_cmd.lane) == l) begin
                omem[i_cmd.grp] <= i_cmd.value;
            end
            r_w_rd[l]   <= wmem[rd_addr];
            r_b_rd[l]   <= bmem[r_g];
            r_ow_rd[l]  <= omem[r_g];
            r_acc_rd[l] <= amem[r_g];
            if (r_s1_v && r_op == OP_CLR) begin
                amem[r_s1_g] <= 32'(r_b_rd[l]);
            end else if (r_s1_v && (r_op == OP_ADD || r_op == OP_SUB)) begin
                amem[r_s1_g] <= sat;
            end
            r_prod[l] <= relu * r_ow_rd[l];
        end
    end

    for (genvar q = 0; q < NQ; q++) begin : g_part
        logic signed [49:0] ps;
        always_comb begin
            ps = '0;
            for (int j = 0; j < 4; j++) begin
                if (q * 4 + j < LANES) begin
                    ps = ps + 50'(r_prod[(q * 4 + j) % LANES]);
                end
            end
        end
        always_ff @(posedge i_clk) begin
            r_part[q] <= ps;
        end
    end

    always_comb begin
        part_sum = '0;
        for (int q = 0; q < NQ; q++) begin
            part_sum = part_sum + 64'(r_part[q]);
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= ST_IDLE;
            r_acc_valid <= 1'b0;
            r_row_ok    <= '0;
            r_obias     <= '0;
            r_out_v     <= 1'b0;
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_s3_v      <= 1'b0;
            r_g         <= '0;
            r_dr        <= '0;
        end else begin
            if (i_cfg_we) begin
                r_obias <= i_cfg_data;
            end
            if (pop && r_out_v) begin
                r_out_v <= 1'b0;
            end
            r_s1_v <= run;
            r_s2_v <= r_s1_v && r_op == OP_SCR;
            r_s3_v <= r_s2_v;
            if (r_s1_v && r_op == OP_CLR) begin
                r_row_ok[r_s1_g] <= 1'b1;
            end
            case (r_st)
                ST_IDLE: begin
                    if (start) begin
                        r_g <= '0;
                        case (i_cmd.op)
                            OP_WL1, OP_WB, OP_WO, OP_INV: r_acc_valid <= 1'b0;
                            OP_CLR: begin
                                r_acc_valid <= 1'b1;
                                r_st        <= ST_RUN;
                            end
                            OP_ADD, OP_SUB: begin
                                if (r_acc_valid) begin
                                    r_st <= ST_RUN;
                                end
                            end
                            OP_SCR: r_st <= ST_RUN;
                            default: r_st <= ST_IDLE;
                        endcase
                    end
                end
                ST_RUN: begin
                    r_g <= r_g + GW'(1);
                    if (last_g) begin
                        r_st <= ST_DRAIN;
                        r_dr <= '0;
                    end
                end
                ST_DRAIN: begin
                    r_dr <= r_dr + 2'd1;
                    if (r_dr == 2'd3) begin
                        r_st <= ST_IDLE;
                        if (r_op == OP_SCR) begin
                            r_out_v <= 1'b1;
                        end
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_op   <= i_cmd.op;
            r_feat <= i_cmd.feat;
            r_sum  <= 64'(r_obias);
        end else if (r_s3_v) begin
            // bounded well below 2^63 at these sizes, no saturation needed
            r_sum <= r_sum + part_sum;
        end
        r_s1_g  <= r_g;
        r_s1_ok <= r_row_ok[r_g];
        if (r_st == ST_DRAIN && r_dr == 2'd3) begin
            r_out.score     <= r_sum;
            r_out.was_valid <= r_acc_valid;
        end
    end

endmodule

[rtl/core/nnue_accumulator_evaluator.sv]
// ----------------------------------------------------------------------------
// nnue_accumulator_evaluator
// Two-layer NNUE evaluator: weight store, hidden accumulator and scorer.
// ----------------------------------------------------------------------------
// Weight, bias and output-weight writes are done as the engine takes them, and
// so are ignored words that get that far. Clear, add, remove and score walk
// the hidden layer LANES neurons at a time: a start step, a pass over the
// HIDDEN/LANES groups (16 here) of the lane memories and a drain of the read
// and multiply pipeline; add and remove are dropped while the accumulator is
// not valid. A score waits while the previous score still sits unpopped on
// the result port. A four-entry command queue lets the input side keep taking
// words while the engine is busy, until it fills. The accumulator reads as
// zero after reset without a clearing pass.
module nnue_accumulator_evaluator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  nnue_pkg::t_in      i_in,
    output logic               empty,
    input  logic               pop,
    output nnue_pkg::t_out     o_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic signed [31:0] i_cfg_data
);
    import nnue_pkg::*;

    logic cmd_v, q_full, q_empty, q_pop;
    t_cmd cmd, q_cmd;

    assign o_cfg_ready = 1'b1;

    nnue_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in       (i_in),
        .o_cmd_v    (cmd_v),
        .o_cmd      (cmd),
        .i_cmd_full (q_full)
    );

    nnue_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cmd_v),
        .i_wdata (cmd),
        .o_full  (q_full),
        .i_rd    (q_pop),
        .o_empty (q_empty),
        .o_rdata (q_cmd)
    );

    nnue_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (q_empty),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .empty       (empty),
        .pop         (pop),
        .o_out       (o_out)
    );

endmodule
